FILE: sv/csf_pkg.sv
// Shared types and constants for the code-aware substring finder.
// No dependencies; imported by every module of the block.
`default_nettype none

package csf_pkg;

   // Default sizes for the top-level parameters
   localparam int MAX_NEEDLE_DEF = 32;
   localparam int MAX_LINE_DEF   = 4096;

   // Fixed field widths
   localparam int BYTE_W     = 8;
   localparam int COLUMN_W   = 12;
   localparam int NLEN_CSR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int BYTES_PER_WORD = CSR_DATA_W / BYTE_W;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_WORD0  = 3'd1;

   // Character codes
   localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE     = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0D;

   // Leading-byte scan for comment lines
   typedef enum logic [2:0] {
      PHASE_SKIP  = 3'b001,
      PHASE_SLASH = 3'b010,
      PHASE_DONE  = 3'b100
   } phase_type;

   // State handed from one match cell to the next
   typedef struct packed {
      logic pm;   // needle prefix ends here
      logic qh;   // quote state before the byte this cell lines up with
   } cell_link_type;

   // Line-level lexer status toward the top level
   typedef struct packed {
      logic inside_quotes;   // quote state before the current byte
      logic comment_now;     // comment flag including the current byte
   } lex_status_type;

endpackage

`default_nettype wire

FILE: sv/code_aware_substring_finder_unit.sv
// Top level of the code-aware substring finder: cell chain, lexer,
// match bookkeeping and the result register. Depends on csf_pkg,
// csf_cell and csf_lexer.
`default_nettype none

// Streams a text line one byte per request and, on the request marked
// last_of_line, returns one result: the column of the first needle match
// that does not start inside double quotes, with a flag for lines whose
// first two non-space bytes are "//". A byte is taken every cycle, save a
// stalled final byte: each of the MAX_NEEDLE match cells compares its needle
// byte with the incoming byte and shifts its partial-match bit to its
// neighbor, and the result appears in the result register on the cycle after
// the last byte. Non-final bytes are taken even while a result is stalled;
// only a final byte waits for the result register to drain. An empty needle
// always reports a match at column 0. Matches starting at or beyond MAX_LINE
// are ignored. The needle is written through the csr port (index 0 length,
// 1..4 needle bytes, eight per word) between lines.
module code_aware_substring_finder_unit
   import csf_pkg::*;
#(
   parameter int MAX_NEEDLE = MAX_NEEDLE_DEF,
   parameter int MAX_LINE   = MAX_LINE_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [BYTE_W-1:0]      req_text_byte,
   input  wire logic                   req_last_of_line,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_match_found,
   output logic [COLUMN_W-1:0]         rsp_match_column,
   output logic                        rsp_comment_line,
   // configuration writes
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NLEN_W  = $clog2(MAX_NEEDLE + 1);
   localparam int POS_MAX = MAX_LINE + MAX_NEEDLE;
   localparam int POS_W   = $clog2(POS_MAX + 1);
   localparam int START_W = POS_W + 1;

   // Handshake
   logic accept;
   logic line_end;

   // Configuration
   logic [NLEN_CSR_W-1:0] nlen_ff;
   logic [NLEN_W-1:0]     len_eff;

   // Cell chain
   cell_link_type  link_ff [MAX_NEEDLE];
   cell_link_type  link_in [MAX_NEEDLE];
   lex_status_type lex;

   // Line bookkeeping
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                seen_ff;
   logic [COLUMN_W-1:0] col_ff;
   logic [START_W-1:0]  start;
   logic                pm_sel, qh_sel, hit;
   logic                seen_now;
   logic [COLUMN_W-1:0] col_now;

   // Result register
   logic                rsp_valid_ff;
   logic                found_ff, comment_ff;
   logic [COLUMN_W-1:0] rcol_ff;
   logic                found_in;
   logic [COLUMN_W-1:0] rcol_in;

   // Only a final byte needs the result register free
   assign req_stall = rsp_valid_ff && rsp_stall && req_last_of_line;
   assign accept    = req_valid && !req_stall;
   assign line_end  = req_last_of_line;

   always_ff @(posedge clock) begin
      if (reset) begin
         nlen_ff <= '0;
      end else if (csr_write_enable && (csr_index == CSR_NEEDLE_LENGTH)) begin
         nlen_ff <= csr_wdata[NLEN_CSR_W-1:0];
      end
   end

   // lengths above the cell count saturate
   assign len_eff = (nlen_ff > NLEN_CSR_W'(MAX_NEEDLE))
                    ? NLEN_W'(MAX_NEEDLE) : NLEN_W'(nlen_ff);

   csf_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .line_end  (line_end),
      .text_byte (req_text_byte),
      .status    (lex)
   );

   // Cell k matches needle byte k; cell 0 starts a fresh prefix on every
   // byte and records the quote state ahead of that byte.
   for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
      localparam int WORD = k / BYTES_PER_WORD;
      localparam int LANE = k % BYTES_PER_WORD;
      cell_link_type prev;
      logic          we;

      if (k == 0) begin : g_head
         assign prev.pm = 1'b1;
         assign prev.qh = lex.inside_quotes;
      end else begin : g_body
         assign prev = link_ff[k-1];
      end

      assign we = csr_write_enable
                  && (csr_index == CSR_NEEDLE_WORD0 + CSR_INDEX_W'(WORD));

      csf_cell #(
         .CELL_INDEX (k),
         .NLEN_W     (NLEN_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .line_end     (line_end),
         .text_byte    (req_text_byte),
         .len_eff      (len_eff),
         .needle_we    (we),
         .needle_wdata (csr_wdata[LANE*BYTE_W +: BYTE_W]),
         .link_prev    (prev),
         .link_ff      (link_ff[k]),
         .link_in      (link_in[k])
      );
   end

   // Pick the cell at the needle's last byte (AND-OR select)
   always_comb begin
      pm_sel = 1'b0;
      qh_sel = 1'b0;
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         if (NLEN_W'(k + 1) == len_eff) begin
            pm_sel = link_in[k].pm;
            qh_sel = link_in[k].qh;
         end
      end
   end

   // Match start column; a full match implies pos >= len - 1
   assign start = START_W'(pos_ff) - START_W'(len_eff) + START_W'(1);
   assign hit   = (len_eff != '0) && pm_sel && !qh_sel
                  && (start < START_W'(MAX_LINE));

   assign seen_now = seen_ff || hit;
   assign col_now  = seen_ff ? col_ff : COLUMN_W'(start);
   assign pos_in   = (pos_ff < POS_W'(POS_MAX)) ? pos_ff + POS_W'(1) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset || (accept && line_end)) begin
         pos_ff  <= '0;
         seen_ff <= 1'b0;
         col_ff  <= '0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         seen_ff <= seen_now;
         col_ff  <= col_now;
      end
   end

   // Result for the line
   always_comb begin
      if (len_eff == '0) begin
         found_in = 1'b1;
         rcol_in  = '0;
      end else if (lex.comment_now || !seen_now) begin
         found_in = 1'b0;
         rcol_in  = '0;
      end else begin
         found_in = 1'b1;
         rcol_in  = col_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && line_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && line_end) begin
         found_ff   <= found_in;
         rcol_ff    <= rcol_in;
         comment_ff <= lex.comment_now;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_found  = found_ff;
   assign rsp_match_column = rcol_ff;
   assign rsp_comment_line = comment_ff;

   // A new result only follows a final byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && line_end))
      else $error("result appeared without a final byte");

   // A comment line reports a match only for the empty needle, at column 0
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && comment_ff && found_ff) |-> (rcol_ff == '0))
      else $error("comment line reported a nonzero column");

   // Line state is cleared after the final byte
   assert property (@(posedge clock) disable iff (reset)
      (accept && line_end) |=> (pos_ff == '0) && !seen_ff)
      else $error("line state not cleared");

   // Position counter never passes its saturation limit
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(POS_MAX))
      else $error("byte position overran its limit");

endmodule

`default_nettype wire

FILE: sv/csf_cell.sv
// One match cell: holds one needle byte, one partial-match bit and one
// quote-history bit. Depends on csf_pkg.
`default_nettype none

module csf_cell
   import csf_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int NLEN_W     = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              line_end,
   input  wire logic [BYTE_W-1:0] text_byte,
   input  wire logic [NLEN_W-1:0] len_eff,
   input  wire logic              needle_we,
   input  wire logic [BYTE_W-1:0] needle_wdata,
   input  wire cell_link_type     link_prev,
   output cell_link_type          link_ff,
   output cell_link_type          link_in
);

   logic [BYTE_W-1:0] needle_ff;
   logic              active;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff <= '0;
      end else if (needle_we) begin
         needle_ff <= needle_wdata;
      end
   end

   assign active     = NLEN_W'(CELL_INDEX) < len_eff;
   assign link_in.pm = link_prev.pm && active && (needle_ff == text_byte);
   assign link_in.qh = link_prev.qh;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else if (accept) begin
         link_ff <= line_end ? cell_link_type'('0) : link_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/csf_lexer.sv
// Line lexer: quote tracking with backslash escapes and the comment check
// on the first two non-space bytes. Depends on csf_pkg.
`default_nettype none

module csf_lexer
   import csf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              line_end,
   input  wire logic [BYTE_W-1:0] text_byte,
   output lex_status_type         status
);

   logic      inside_ff, inside_in;
   logic      bs_odd_ff, bs_odd_in;
   logic      comment_ff, comment_in;
   phase_type phase_ff, phase_in;
   logic      is_space;

   always_comb begin
      is_space = text_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
      phase_in   = phase_ff;
      comment_in = comment_ff;
      case (phase_ff)
         PHASE_SKIP: begin
            if (!is_space) begin
               phase_in = (text_byte == CHAR_SLASH) ? PHASE_SLASH : PHASE_DONE;
            end
         end
         PHASE_SLASH: begin
            if (text_byte == CHAR_SLASH) begin
               comment_in = 1'b1;
            end
            phase_in = PHASE_DONE;
         end
         default: begin
            phase_in = PHASE_DONE;
         end
      endcase

      inside_in = inside_ff ^ ((text_byte == CHAR_QUOTE) && !bs_odd_ff);
      bs_odd_in = (text_byte == CHAR_BACKSLASH) ? !bs_odd_ff : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && line_end)) begin
         inside_ff  <= 1'b0;
         bs_odd_ff  <= 1'b0;
         comment_ff <= 1'b0;
         phase_ff   <= PHASE_SKIP;
      end else if (accept) begin
         inside_ff  <= inside_in;
         bs_odd_ff  <= bs_odd_in;
         comment_ff <= comment_in;
         phase_ff   <= phase_in;
      end
   end

   assign status.inside_quotes = inside_ff;
   assign status.comment_now   = comment_in;

endmodule

`default_nettype wire

FILE: bench/finder_check_pkg.sv
// Line-result scoreboard for the code-aware substring finder bench.
// Depends on csf_pkg for widths, character codes and the leading-byte phase type.
`timescale 1ns / 100ps

package finder_check_pkg;
   import csf_pkg::*;

   typedef logic [BYTE_W-1:0] text_queue_type[$];

   typedef struct packed {
      logic                found;
      logic [COLUMN_W-1:0] column;
      logic                comment;
   } line_result_type;

   class finder_scoreboard;
      logic [NLEN_CSR_W-1:0]     needle_len_reg;
      logic [CSR_DATA_W-1:0]     needle_word [4];
      logic [MAX_NEEDLE_DEF-1:0] prefix_hits;   // bit k: needle[0..k] ends at latest byte
      logic [MAX_NEEDLE_DEF-1:0] quote_trail;   // bit k: quote state k bytes before latest
      bit                        in_quotes;
      bit                        odd_backslashes;
      int unsigned               column_pos;
      bit                        found_any;
      logic [COLUMN_W-1:0]       found_col;
      phase_type                 lead_phase;
      bit                        comment_seen;
      line_result_type           pending_line_results[$];
      int                        failures;

      function new();
         needle_len_reg = '0;
         foreach (needle_word[i]) needle_word[i] = '0;
         failures = 0;
         clear_line();
      endfunction

      function void clear_line();
         prefix_hits     = '0;
         quote_trail     = '0;
         in_quotes       = 1'b0;
         odd_backslashes = 1'b0;
         column_pos      = 0;
         found_any       = 1'b0;
         found_col       = '0;
         lead_phase      = PHASE_SKIP;
         comment_seen    = 1'b0;
      endfunction

      function int outstanding();
         return pending_line_results.size();
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_NEEDLE_LENGTH)
            needle_len_reg = data[NLEN_CSR_W-1:0];
         else if (index >= CSR_NEEDLE_WORD0 && index < CSR_NEEDLE_WORD0 + 4)
            needle_word[index - CSR_NEEDLE_WORD0] = data;
      endfunction

      // Advance the line state by one accepted byte; queue the line result on the last one.
      function void scan_byte(logic [BYTE_W-1:0] c, logic last);
         int unsigned               used_len;
         int unsigned               start;
         logic [MAX_NEEDLE_DEF-1:0] hits_now;
         logic [BYTE_W-1:0]         nb;
         bit                        blank;
         line_result_type           r;

         used_len = (needle_len_reg > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : needle_len_reg;
         blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);

         case (lead_phase)
            PHASE_SKIP: begin
               if (!blank)
                  lead_phase = (c == CHAR_SLASH) ? PHASE_SLASH : PHASE_DONE;
            end
            PHASE_SLASH: begin
               if (c == CHAR_SLASH)
                  comment_seen = 1'b1;
               lead_phase = PHASE_DONE;
            end
            default: lead_phase = PHASE_DONE;
         endcase

         quote_trail = {quote_trail[MAX_NEEDLE_DEF-2:0], in_quotes};

         hits_now = '0;
         for (int unsigned k = 0; k < used_len; k++) begin
            nb = needle_word[k / BYTES_PER_WORD][(k % BYTES_PER_WORD) * BYTE_W +: BYTE_W];
            if (nb == c)
               hits_now[k] = 1'b1;
         end
         prefix_hits = ((prefix_hits << 1) | 1) & hits_now;

         if (used_len > 0 && prefix_hits[used_len-1]) begin
            start = column_pos - (used_len - 1);
            if (!found_any && !quote_trail[used_len-1] && start < MAX_LINE_DEF) begin
               found_any = 1'b1;
               found_col = start[COLUMN_W-1:0];
            end
         end

         if (c == CHAR_QUOTE && !odd_backslashes)
            in_quotes = !in_quotes;
         odd_backslashes = (c == CHAR_BACKSLASH) ? !odd_backslashes : 1'b0;

         if (column_pos < MAX_LINE_DEF + MAX_NEEDLE_DEF)
            column_pos++;

         if (last) begin
            r.comment = comment_seen;
            if (used_len == 0) begin
               r.found  = 1'b1;
               r.column = '0;
            end else if (comment_seen || !found_any) begin
               r.found  = 1'b0;
               r.column = '0;
            end else begin
               r.found  = 1'b1;
               r.column = found_col;
            end
            pending_line_results = {pending_line_results, r};
            clear_line();
         end
      endfunction

      function void check_result(logic found, logic [COLUMN_W-1:0] column, logic comment);
         line_result_type want;
         if (pending_line_results.size() == 0) begin
            $error("unexpected result: match_found %0d match_column %0d comment_line %0d",
                   found, column, comment);
            failures++;
         end else begin
            want = pending_line_results.pop_front();
            if (want.found !== found) begin
               $error("match_found: expected %0d, got %0d", want.found, found);
               failures++;
            end
            if (want.column !== column) begin
               $error("match_column: expected %0d, got %0d", want.column, column);
               failures++;
            end
            if (want.comment !== comment) begin
               $error("comment_line: expected %0d, got %0d", want.comment, comment);
               failures++;
            end
         end
      endfunction

      function void finish_check();
         if (pending_line_results.size() != 0) begin
            $error("%0d line results never arrived", pending_line_results.size());
            failures++;
         end
      endfunction
   endclass

endpackage

FILE: bench/tb.sv
// Top-level bench for code_aware_substring_finder_unit: drives text lines and needle setups.
// Depends on csf_pkg and finder_check_pkg (scoreboard with the line predictor).
`timescale 1ns / 100ps

module tb;
   import csf_pkg::*;
   import finder_check_pkg::*;

   // Cycles with no request, result or csr write before the run is declared hung.
   // The long result hold-off is the longest such stretch; everything else is far shorter.
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int BYTES_PER_SETTING = 315;

   // Indexes past the needle words; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = CSR_NEEDLE_WORD0 + 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LAST  = '1;

   localparam logic [BYTE_W-1:0] CHAR_A    = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_B    = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_X    = 8'h78;

   typedef enum {NEEDLE_TEXT, NEEDLE_ANY, NEEDLE_ONES} needle_mix_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_text_byte;
   logic                   req_last_of_line;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_match_found;
   logic [COLUMN_W-1:0]    rsp_match_column;
   logic                   rsp_comment_line;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   finder_scoreboard line_checker = new();

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int bytes_sent  = 0;
   int idle_cycles;
   bit long_hold_request = 1'b0;
   int long_hold_left    = 0;

   // Copy of the needle in use, so random lines can embed it
   logic [BYTE_W-1:0] needle_copy [MAX_NEEDLE_DEF];
   int                needle_used = 0;

   code_aware_substring_finder_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_last_of_line (req_last_of_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_column (rsp_match_column),
      .rsp_comment_line (rsp_comment_line),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request side. Inputs move on the falling edge only; acceptance is
   // judged at the rising edge. Valid stays up after an accepted request
   // until the next falling edge, where the next call either drops it
   // (idle) or presents the next byte - one assignment per edge.
   // ---------------------------------------------------------------------
   task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_text_byte    = b;
      req_last_of_line = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      line_checker.scan_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_line(input text_queue_type text);
      foreach (text[i]) offer_byte(text[i], i == text.size() - 1);
   endtask

   // Drop valid, then wait until every queued line result has come back.
   // A line result is registered in the cycle after its last byte; the extra
   // wait afterwards leaves the block idle for csr writes.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (line_checker.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_wdata        = value;
      @(posedge clock);
      line_checker.write_register(idx, value);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Bytes that steer the lexer: quotes, backslashes, slashes, spaces, letters
   function automatic logic [BYTE_W-1:0] text_char();
      case ($urandom_range(6))
         0: return CHAR_QUOTE;
         1: return CHAR_BACKSLASH;
         2: return CHAR_SLASH;
         3: return CHAR_SPACE;
         default: return BYTE_W'(CHAR_A + $urandom_range(2));
      endcase
   endfunction

   // Writes every register; the length word carries random upper bits that
   // the block must drop, and one write goes to an unused index.
   task automatic load_needle(input logic [NLEN_CSR_W-1:0] len_value,
                              input needle_mix_type mix);
      logic [CSR_DATA_W-1:0] word;
      logic [BYTE_W-1:0]     nb;
      needle_used = (len_value > MAX_NEEDLE_DEF) ? MAX_NEEDLE_DEF : len_value;
      csr_write(CSR_NEEDLE_LENGTH, {$urandom(), 26'($urandom()), len_value});
      for (int w = 0; w < 4; w++) begin
         for (int b = 0; b < BYTES_PER_WORD; b++) begin
            case (mix)
               NEEDLE_ONES: nb = '1;
               NEEDLE_ANY:  nb = BYTE_W'($urandom_range(255));
               default:     nb = text_char();
            endcase
            word[b*BYTE_W +: BYTE_W]       = nb;
            needle_copy[w*BYTES_PER_WORD + b] = nb;
         end
         csr_write(CSR_INDEX_W'(CSR_NEEDLE_WORD0 + w), word);
      end
      csr_write(CSR_INDEX_W'(CSR_UNUSED_FIRST + $urandom_range(2)), {$urandom(), $urandom()});
   endtask

   // Random line: sometimes a comment lead-in, then a mix of whole and
   // partial needles, quotes, backslashes and arbitrary bytes.
   function automatic text_queue_type make_line(input int unsigned target_len);
      text_queue_type line;
      int unsigned    cut;
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(3))
            line = {line, $urandom_range(1) ? CHAR_SPACE
                                            : BYTE_W'(CHAR_TAB + $urandom_range(4))};
         line = {line, CHAR_SLASH};
         if ($urandom_range(3) != 0)
            line = {line, CHAR_SLASH};
      end
      while (line.size() < target_len) begin
         case ($urandom_range(9))
            0, 1: begin
               if (needle_used > 0) begin
                  cut = ($urandom_range(2) == 0) ? $urandom_range(1, needle_used) : needle_used;
                  for (int unsigned k = 0; k < cut; k++) line = {line, needle_copy[k]};
               end else begin
                  line = {line, CHAR_A};
               end
            end
            2: line = {line, CHAR_QUOTE};
            3: line = {line, CHAR_BACKSLASH};
            4: line = {line, BYTE_W'($urandom_range(255))};
            5: line = {line, (needle_used > 0) ? needle_copy[$urandom_range(needle_used - 1)]
                                               : CHAR_SPACE};
            default: line = {line, text_char()};
         endcase
      end
      return line;
   endfunction

   // ---------------------------------------------------------------------
   // Result side. Stall changes on the falling edge; a long hold-off, when
   // requested, is counted here so the sender keeps pushing meanwhile.
   // ---------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            long_hold_left    = LONG_HOLD_CYCLES;
         end
         if (long_hold_left > 0) begin
            rsp_stall = 1'b1;
            long_hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         line_checker.check_result(rsp_match_found, rsp_match_column, rsp_comment_line);
   end

   // Watchdog: counts cycles without any handshake or csr write
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int      setting_start;
      bit      paused_once;

      paused_once      = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_text_byte    = '0;
      req_last_of_line = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Needle left empty from reset: always a match at column 0,
      // and the comment flag still reported.
      send_line('{CHAR_X});
      send_line('{CHAR_SLASH, CHAR_SLASH});

      settle();
      csr_write(CSR_NEEDLE_LENGTH, 2);
      csr_write(CSR_NEEDLE_WORD0, {48'd0, CHAR_B, CHAR_A});
      csr_write(CSR_UNUSED_LAST, '1);

      // Needle "ab": comment after leading blanks, a quoted hit followed
      // by a plain one, an escaped quote that does not open a string,
      // a lone slash that is not a comment, and the byte extremes.
      send_line('{CHAR_SPACE, CHAR_TAB, CHAR_SLASH, CHAR_SLASH, CHAR_A, CHAR_B});
      send_line('{CHAR_QUOTE, CHAR_A, CHAR_B, CHAR_QUOTE, CHAR_A, CHAR_B});
      send_line('{CHAR_BACKSLASH, CHAR_QUOTE, CHAR_A, CHAR_B});
      send_line('{CHAR_SLASH, CHAR_A, CHAR_B});
      send_line('{8'h00, 8'hFF});

      // Random lines: three idling regimes, two needle setups each,
      // covering lengths 0, 1, 32 and an oversized length that clamps.
      for (int mode = 0; mode < 3; mode++) begin
         for (int setting = 0; setting < 2; setting++) begin
            settle();
            case (mode)
               0:       begin tx_idle_pct = 15; rx_idle_pct = 82; end
               1:       begin tx_idle_pct = 82; rx_idle_pct = 15; end
               default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            case (mode * 2 + setting)
               0:       load_needle(1, NEEDLE_TEXT);
               1:       load_needle(32, NEEDLE_TEXT);
               2:       load_needle(63, NEEDLE_ANY);
               3:       load_needle(0, NEEDLE_TEXT);
               4:       load_needle(NLEN_CSR_W'($urandom_range(2, 6)), NEEDLE_TEXT);
               default: load_needle(32, NEEDLE_ONES);
            endcase
            // Back-pressure long enough for a final byte to be held at the input
            if (mode == 0 && setting == 0)
               long_hold_request = 1'b1;
            setting_start = bytes_sent;
            while (bytes_sent - setting_start < BYTES_PER_SETTING) begin
               if (mode == 1 && setting == 0 && !paused_once &&
                   bytes_sent - setting_start > BYTES_PER_SETTING / 2) begin
                  paused_once = 1'b1;
                  settle();
               end
               send_line(make_line($urandom_range(1, 10 + 2 * needle_used)));
            end
         end
      end

      settle();
      repeat (8) @(posedge clock);
      line_checker.finish_check();
      if (line_checker.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
sv/csf_pkg.sv
sv/csf_cell.sv
sv/csf_lexer.sv
sv/code_aware_substring_finder_unit.sv
bench/finder_check_pkg.sv
bench/tb.sv
